>>> src/xor_pair_below_limit_counter_defines.svh
// Assertion macros for the XOR pair counter.
`ifndef XOR_PAIR_BELOW_LIMIT_COUNTER_DEFINES_SVH
`define XOR_PAIR_BELOW_LIMIT_COUNTER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked on every rising edge out of reset.
`define XPBL_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("xpbl assertion failed");
// Next-cycle implication.
`define XPBL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("xpbl assertion failed");
`else
`define XPBL_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define XPBL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> src/xpbl_pkg.sv
// Shared types and constants of the XOR pair counter.
`default_nettype none

package xpbl_pkg;

	localparam int MAX_ITEMS_DEF  = 1024;
	localparam int VALUE_BITS_DEF = 32;
	localparam int NODE_SLOTS_DEF = 32768;

	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 32;
	localparam int LIMIT_W    = 32;
	localparam int PAIRS_W    = 10;
	localparam int TOTAL_W    = 19;

	localparam int unsigned PAIRS_MAX = 1023;
	localparam int unsigned TOTAL_MAX = 524287;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_QUERY,
		ST_PRE,
		ST_INS,
		ST_DONE
	} state_t;

	// One result beat, pairs in the lowest bits.
	typedef struct packed {
		logic               overflow;
		logic [TOTAL_W-1:0] total;
		logic [PAIRS_W-1:0] pairs;
	} res_t;

endpackage

`default_nettype wire

>>> src/xpbl_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none

module xpbl_ram #(
	parameter  int WIDTH  = 8,
	parameter  int DEPTH  = 64,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

>>> src/xpbl_engine.sv
// Trie walk sequencer: query walk, optional room check, insert walk.
`default_nettype none

module xpbl_engine #(
	parameter  int MAX_ITEMS  = xpbl_pkg::MAX_ITEMS_DEF,
	parameter  int VALUE_BITS = xpbl_pkg::VALUE_BITS_DEF,
	parameter  int NODE_SLOTS = xpbl_pkg::NODE_SLOTS_DEF,
	localparam int IDX_W      = $clog2(NODE_SLOTS),
	localparam int HIT_W      = $clog2(MAX_ITEMS + 1),
	localparam int ENT_W      = 2 * (IDX_W + HIT_W)
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [xpbl_pkg::IN_DATA_W-1:0]     in_value,
	input  logic                               in_start,
	input  logic                               cfg_we,
	input  logic [xpbl_pkg::LIMIT_W-1:0]       cfg_wdata,
	output logic                               res_valid,
	input  logic                               res_ready,
	output xpbl_pkg::res_t                     res,
	output logic                               rd_en,
	output logic [IDX_W-1:0]                   rd_addr,
	input  logic [ENT_W-1:0]                   rd_data,
	output logic                               wr_en,
	output logic [IDX_W-1:0]                   wr_addr,
	output logic [ENT_W-1:0]                   wr_data
);

	import xpbl_pkg::*;

	localparam int LVL_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
	localparam int NU_W  = $clog2(NODE_SLOTS + 1);
	localparam logic [LVL_W-1:0] LVL_TOP = LVL_W'(VALUE_BITS - 1);

	state_t state_q, state_d;

	logic [LVL_W-1:0]      lvl_q;
	logic [IDX_W-1:0]      node_q;
	logic                  fresh_q;
	logic [VALUE_BITS-1:0] v_q;
	logic [HIT_W-1:0]      cnt_q;
	logic                  ovf_q;
	logic [IDX_W-1:0]      root0_q, root1_q;
	logic [HIT_W-1:0]      rhits0_q, rhits1_q;
	logic [NU_W-1:0]       nodes_q;
	logic [HIT_W-1:0]      items_q;
	logic [TOTAL_W-1:0]    total_q;
	logic [LIMIT_W-1:0]    lim_q;

	// Node word: {hits of one child, hits of zero child, one child, zero child}.
	logic [ENT_W-1:0]      ent, new_ent;
	logic [IDX_W-1:0]      e_c0, e_c1, same_c, other_c, q_next, k_node;
	logic [HIT_W-1:0]      e_h0, e_h1, same_h, cnt_nx, cnt_fin, hit_inc;
	logic [VALUE_BITS-1:0] lim_lo;
	logic                  bit_v, bit_l, wide, q_end, alloc;
	logic                  ins_full, nodes_tight, need_ovf;
	logic [TOTAL_W:0]      sum_w;
	logic [TOTAL_W-1:0]    total_nx;

	assign lim_lo = lim_q[VALUE_BITS-1:0];
	assign wide   = (lim_q >> VALUE_BITS) != '0;

	// The root lives in flops so an emptied set needs no memory pass.
	always_comb begin
		if (fresh_q) begin
			ent = '0;
		end else if (node_q == '0) begin
			ent = {rhits1_q, rhits0_q, root1_q, root0_q};
		end else begin
			ent = rd_data;
		end
	end

	assign e_c0 = ent[IDX_W-1:0];
	assign e_c1 = ent[2*IDX_W-1:IDX_W];
	assign e_h0 = ent[2*IDX_W+HIT_W-1:2*IDX_W];
	assign e_h1 = ent[ENT_W-1:2*IDX_W+HIT_W];

	assign bit_v   = v_q[lvl_q];
	assign bit_l   = lim_lo[lvl_q];
	assign same_c  = bit_v ? e_c1 : e_c0;
	assign other_c = bit_v ? e_c0 : e_c1;
	assign same_h  = bit_v ? e_h1 : e_h0;

	assign q_next  = bit_l ? other_c : same_c;
	assign cnt_nx  = cnt_q + (bit_l ? same_h : '0);
	assign q_end   = wide || (q_next == '0) || (lvl_q == '0);
	assign cnt_fin = wide ? items_q : cnt_nx;

	assign sum_w    = {1'b0, total_q} + (TOTAL_W + 1)'(cnt_fin);
	assign total_nx = (sum_w > (TOTAL_W + 1)'(TOTAL_MAX)) ? TOTAL_W'(TOTAL_MAX)
	                                                      : sum_w[TOTAL_W-1:0];

	assign ins_full    = items_q >= HIT_W'(MAX_ITEMS);
	assign nodes_tight = ({1'b0, nodes_q} + (NU_W + 1)'(VALUE_BITS))
	                     > (NU_W + 1)'(NODE_SLOTS);
	assign need_ovf    = ({1'b0, nodes_q} + (NU_W + 1)'(lvl_q) + (NU_W + 1)'(1))
	                     > (NU_W + 1)'(NODE_SLOTS);

	assign alloc   = same_c == '0;
	assign k_node  = alloc ? nodes_q[IDX_W-1:0] : same_c;
	assign hit_inc = same_h + HIT_W'(1);

	always_comb begin
		new_ent = ent;
		if (bit_v) begin
			new_ent[2*IDX_W-1:IDX_W]           = k_node;
			new_ent[ENT_W-1:2*IDX_W+HIT_W]     = hit_inc;
		end else begin
			new_ent[IDX_W-1:0]                 = k_node;
			new_ent[2*IDX_W+HIT_W-1:2*IDX_W]   = hit_inc;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_QUERY;
				end
			end
			ST_QUERY: begin
				if (q_end) begin
					if (ins_full) begin
						state_d = ST_DONE;
					end else if (nodes_tight) begin
						state_d = ST_PRE;
					end else begin
						state_d = ST_INS;
					end
				end
			end
			ST_PRE: begin
				if (alloc) begin
					state_d = need_ovf ? ST_DONE : ST_INS;
				end else if (lvl_q == '0) begin
					state_d = ST_INS;
				end
			end
			ST_INS: begin
				if (lvl_q == '0) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs and memory commands.
	always_comb begin
		in_ready  = 1'b0;
		res_valid = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = same_c;
		wr_en     = 1'b0;
		wr_addr   = node_q;
		wr_data   = new_ent;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
			end
			ST_QUERY: begin
				rd_en   = !q_end;
				rd_addr = q_next;
			end
			ST_PRE: begin
				rd_en = !alloc && (lvl_q != '0);
			end
			ST_INS: begin
				// Write the parent back while the child is fetched: never the same slot.
				wr_en = node_q != '0;
				rd_en = !alloc && (lvl_q != '0);
			end
			ST_DONE: begin
				res_valid = 1'b1;
			end
			default: ;
		endcase
	end

	assign res.pairs    = (32'(cnt_q) > PAIRS_MAX) ? PAIRS_W'(PAIRS_MAX) : PAIRS_W'(cnt_q);
	assign res.total    = total_q;
	assign res.overflow = ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			lvl_q    <= '0;
			node_q   <= '0;
			fresh_q  <= 1'b0;
			cnt_q    <= '0;
			ovf_q    <= 1'b0;
			root0_q  <= '0;
			root1_q  <= '0;
			rhits0_q <= '0;
			rhits1_q <= '0;
			nodes_q  <= NU_W'(1);
			items_q  <= '0;
			total_q  <= '0;
			lim_q    <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				lim_q <= cfg_wdata;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						v_q     <= in_value[VALUE_BITS-1:0];
						lvl_q   <= LVL_TOP;
						node_q  <= '0;
						fresh_q <= 1'b0;
						cnt_q   <= '0;
						ovf_q   <= 1'b0;
						if (in_start) begin
							root0_q  <= '0;
							root1_q  <= '0;
							rhits0_q <= '0;
							rhits1_q <= '0;
							nodes_q  <= NU_W'(1);
							items_q  <= '0;
							total_q  <= '0;
						end
					end
				end
				ST_QUERY: begin
					if (q_end) begin
						cnt_q   <= cnt_fin;
						total_q <= total_nx;
						lvl_q   <= LVL_TOP;
						node_q  <= '0;
						ovf_q   <= ins_full;
					end else begin
						cnt_q  <= cnt_nx;
						node_q <= q_next;
						lvl_q  <= lvl_q - LVL_W'(1);
					end
				end
				ST_PRE: begin
					if (alloc || (lvl_q == '0)) begin
						lvl_q  <= LVL_TOP;
						node_q <= '0;
						ovf_q  <= alloc && need_ovf;
					end else begin
						node_q <= same_c;
						lvl_q  <= lvl_q - LVL_W'(1);
					end
				end
				ST_INS: begin
					if (node_q == '0 && !fresh_q) begin
						root0_q  <= new_ent[IDX_W-1:0];
						root1_q  <= new_ent[2*IDX_W-1:IDX_W];
						rhits0_q <= new_ent[2*IDX_W+HIT_W-1:2*IDX_W];
						rhits1_q <= new_ent[ENT_W-1:2*IDX_W+HIT_W];
					end
					if (alloc) begin
						nodes_q <= nodes_q + NU_W'(1);
					end
					if (lvl_q == '0) begin
						items_q <= items_q + HIT_W'(1);
					end else begin
						node_q  <= k_node;
						fresh_q <= alloc;
						lvl_q   <= lvl_q - LVL_W'(1);
					end
				end
				ST_DONE: ;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> src/xpbl_out_reg.sv
// Output register that holds a result beat until the master side takes it.
`default_nettype none

module xpbl_out_reg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            res_valid,
	output logic                            res_ready,
	input  xpbl_pkg::res_t                  res,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [xpbl_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

	import xpbl_pkg::*;

	logic valid_q;
	res_t res_q;

	assign res_ready     = !valid_q || m_axis_tready;
	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = OUT_DATA_W'(res_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_ready) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			res_q <= res;
		end
	end

endmodule

`default_nettype wire

>>> src/xor_pair_below_limit_counter.sv
// Top level of the XOR pair counter: sequencer, node memory, output register.
//
//  channel   dir  handshake                 payload
//  s_axis    in   s_axis_tvalid/tready      tdata[31:0] value, tuser start_set
//  m_axis    out  m_axis_tvalid/tready      tdata pairs[9:0] total[28:10] ovf[29]
//  cfg       in   cfg_we                    cfg_wdata[31:0] xor_limit
//
// An item walks q = 1..VALUE_BITS query levels, then the insert walk; the
// insert walk is skipped when the set already holds MAX_ITEMS values. When fewer
// than VALUE_BITS node slots remain, a room check walk runs before the insert.
// The node memory has one read port, so each walk goes one trie level a cycle.
// Reset needs no clearing pass: the root sits in flops, nodes are written on use.
// A new item is taken while the previous result waits in the output register.
`default_nettype none
`include "xor_pair_below_limit_counter_defines.svh"

module xor_pair_below_limit_counter #(
	parameter int MAX_ITEMS  = xpbl_pkg::MAX_ITEMS_DEF,
	parameter int VALUE_BITS = xpbl_pkg::VALUE_BITS_DEF,
	parameter int NODE_SLOTS = xpbl_pkg::NODE_SLOTS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [xpbl_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // value
	input  logic                            s_axis_tuser,  // start_set
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// pairs_this_item, running_total, overflow, zero fill
	output logic [xpbl_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input  logic                            cfg_we,
	input  logic [xpbl_pkg::LIMIT_W-1:0]    cfg_wdata
);

	import xpbl_pkg::*;

	localparam int IDX_W = $clog2(NODE_SLOTS);
	localparam int HIT_W = $clog2(MAX_ITEMS + 1);
	localparam int ENT_W = 2 * (IDX_W + HIT_W);

	logic             res_valid, res_ready;
	res_t             res;
	logic             rd_en, wr_en;
	logic [IDX_W-1:0] rd_addr, wr_addr;
	logic [ENT_W-1:0] rd_data, wr_data;

	xpbl_engine #(
		.MAX_ITEMS (MAX_ITEMS),
		.VALUE_BITS(VALUE_BITS),
		.NODE_SLOTS(NODE_SLOTS)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_value (s_axis_tdata),
		.in_start (s_axis_tuser),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data)
	);

	xpbl_ram #(
		.WIDTH(ENT_W),
		.DEPTH(NODE_SLOTS)
	) u_nodes (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	xpbl_out_reg u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.res          (res),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	// Read and write-back of one walk step never hit the same node.
	`XPBL_ASSERT_NOW(a_no_rw_clash, clk, arst_n, rd_en && wr_en, rd_addr != wr_addr)
	// The root is held in flops; slot zero of the node memory is never written.
	`XPBL_ASSERT_NOW(a_no_root_write, clk, arst_n, wr_en, wr_addr != '0)
	// One item in flight: after a beat is taken, the input closes.
	`XPBL_ASSERT_NEXT(a_one_item, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
	// No memory traffic while waiting for a new item.
	`XPBL_ASSERT_NOW(a_idle_quiet, clk, arst_n, s_axis_tready, !rd_en && !wr_en && !res_valid)

endmodule

`default_nettype wire

>>> test/tb_top.sv
// Testbench of the XOR pair counter: directed table, clustered random sets, result scoreboard.
`timescale 1ns / 100ps

module tb_top;
	import xpbl_pkg::*;

	localparam int          CYCLE_LIMIT  = 1000000;
	localparam int          DRAIN_CYCLES = 120;
	localparam logic [31:0] LIM_ALL      = 32'hFFFF_FFFF;

	typedef struct packed {
		logic        set_lim;
		logic [31:0] lim;
		logic [31:0] value;
		logic        start;
		logic        typed;
		res_t        want;
	} dir_row_t;

	// Typed rows carry the result; the rest are scored by the pair tally.
	localparam dir_row_t DIRECTED [24] = '{
		'{1'b0, 32'h0,         32'h0000_0000, 1'b1, 1'b1, '{1'b0, 19'd0, 10'd0}},
		'{1'b0, 32'h0,         32'hFFFF_FFFF, 1'b0, 1'b1, '{1'b0, 19'd0, 10'd0}},
		'{1'b0, 32'h0,         32'h0000_0000, 1'b0, 1'b1, '{1'b0, 19'd0, 10'd0}},
		'{1'b1, LIM_ALL,       32'hFFFF_FFFF, 1'b0, 1'b1, '{1'b0, 19'd1, 10'd1}},
		'{1'b0, 32'h0,         32'h0000_0000, 1'b0, 1'b1, '{1'b0, 19'd3, 10'd2}},
		'{1'b1, 32'h1,         32'h8000_0000, 1'b1, 1'b1, '{1'b0, 19'd0, 10'd0}},
		'{1'b0, 32'h0,         32'h8000_0000, 1'b0, 1'b1, '{1'b0, 19'd1, 10'd1}},
		'{1'b0, 32'h0,         32'h8000_0001, 1'b0, 1'b1, '{1'b0, 19'd1, 10'd0}},
		'{1'b0, 32'h0,         32'h8000_0001, 1'b0, 1'b1, '{1'b0, 19'd2, 10'd1}},
		'{1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0, '{1'b0, 19'd0, 10'd0}},
		'{1'b0, 32'h0,         32'h0000_0001, 1'b0, 1'b0, '{1'b0, 19'd0, 10'd0}},
		'{1'b1, 32'h0001_0000, 32'h1234_FFFF, 1'b1, 1'b0, '{1'b0, 19'd0, 10'd0}},
		'{1'b0, 32'h0,         32'h1234_0000, 1'b0, 1'b0, '{1'b0, 19'd0, 10'd0}},
		'{1'b0, 32'h0,         32'h1235_0000, 1'b0, 1'b0, '{1'b0, 19'd0, 10'd0}},
		'{1'b0, 32'h0,         32'hA5A5_A5A5, 1'b0, 1'b0, '{1'b0, 19'd0, 10'd0}},
		'{1'b0, 32'h0,         32'h1234_8000, 1'b0, 1'b0, '{1'b0, 19'd0, 10'd0}},
		'{1'b1, 32'h5A5A_5A5A, 32'h5A5A_5A5A, 1'b1, 1'b0, '{1'b0, 19'd0, 10'd0}},
		'{1'b0, 32'h0,         32'h0000_0000, 1'b0, 1'b0, '{1'b0, 19'd0, 10'd0}},
		'{1'b0, 32'h0,         32'hFFFF_FFFF, 1'b0, 1'b0, '{1'b0, 19'd0, 10'd0}},
		'{1'b0, 32'h0,         32'h00FF_00FF, 1'b0, 1'b0, '{1'b0, 19'd0, 10'd0}},
		'{1'b0, 32'h0,         32'hA5A5_A5A5, 1'b0, 1'b0, '{1'b0, 19'd0, 10'd0}},
		'{1'b1, 32'hFFFF_FFFE, 32'h5555_5555, 1'b1, 1'b0, '{1'b0, 19'd0, 10'd0}},
		'{1'b0, 32'h0,         32'hAAAA_AAAA, 1'b0, 1'b0, '{1'b0, 19'd0, 10'd0}},
		'{1'b0, 32'h0,         32'h5555_5554, 1'b0, 1'b0, '{1'b0, 19'd0, 10'd0}}
	};

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata  = '0;     // value
	logic        s_axis_tuser  = 1'b0;   // start_set
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;           // pairs_this_item, running_total, overflow, zero fill
	logic        cfg_we        = 1'b0;
	logic [31:0] cfg_wdata     = '0;

	// Pair tally state: values held in the current set, its total and the limit.
	logic [31:0] set_values [MAX_ITEMS_DEF];
	int unsigned n_held;
	int unsigned set_total;
	logic [31:0] xor_lim;

	res_t        awaited_tallies [$];
	logic [31:0] cluster_seeds [8];
	bit          idling;
	int          n_errors;
	int          n_results;
	int          stall_left;
	int          cycle_count;

	xor_pair_below_limit_counter i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata)
	);

	always #6 clk = ~clk;

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("tb_top: beat %0d %s mismatch: got %0d, want %0d", n_results, what, got, want);
		n_errors++;
	endtask

	// Count held values whose XOR with v is below the limit, then store v if there is room.
	task automatic tally_pairs(input logic [31:0] v, input logic st, output res_t r);
		int unsigned hits;
		hits = 0;
		if (st) begin
			n_held    = 0;
			set_total = 0;
		end
		for (int k = 0; k < n_held; k++) begin
			if ((v ^ set_values[k]) < xor_lim)
				hits++;
		end
		set_total  = (set_total + hits > TOTAL_MAX) ? TOTAL_MAX : set_total + hits;
		r.pairs    = (hits > PAIRS_MAX) ? PAIRS_MAX[PAIRS_W-1:0] : hits[PAIRS_W-1:0];
		r.total    = set_total[TOTAL_W-1:0];
		r.overflow = (n_held >= MAX_ITEMS_DEF);
		if (!r.overflow) begin
			set_values[n_held] = v;
			n_held++;
		end
	endtask

	task automatic send_value(input logic [31:0] v, input logic st, input logic typed,
		input res_t typed_res);
		res_t r;
		if (idling && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= v;
		s_axis_tuser  <= st;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		tally_pairs(v, st, r);
		awaited_tallies.push_back(typed ? typed_res : r);
	endtask

	// Hold the input until every result is back, then write the limit.
	task automatic write_limit(input logic [31:0] lim);
		s_axis_tvalid <= 1'b0;
		while (awaited_tallies.size() != 0) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= lim;
		@(posedge clk);
		cfg_we    <= 1'b0;
		xor_lim = lim;
	endtask

	task automatic new_clusters();
		logic [31:0] common;
		common = $urandom;
		foreach (cluster_seeds[i])
			cluster_seeds[i] = common ^ ($urandom >> $urandom_range(0, 31));
	endtask

	// Values bunch around a few seeds so the trie walks share long prefixes.
	function automatic logic [31:0] near_value();
		if ($urandom_range(0, 9) == 0)
			return $urandom;
		return cluster_seeds[$urandom_range(0, 7)] ^
			($urandom & (32'hFFFF_FFFF >> $urandom_range(0, 32)));
	endfunction

	function automatic logic [31:0] pick_limit();
		case ($urandom_range(0, 5))
			0: return 32'h0;
			1: return LIM_ALL;
			2: return 32'h1 << $urandom_range(0, 31);
			3: return $urandom >> $urandom_range(0, 31);
			4: return $urandom;
			default: return cluster_seeds[$urandom_range(0, 7)] ^ cluster_seeds[$urandom_range(0, 7)];
		endcase
	endfunction

	always @(posedge clk) begin : score_results
		res_t got;
		res_t want;
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_top: done, errors");
			$finish;
		end
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = res_t'(m_axis_tdata[29:0]);
				if (awaited_tallies.size() == 0) begin
					$display("tb_top: beat %0d arrived with no result awaited", n_results);
					n_errors++;
				end else begin
					want = awaited_tallies.pop_front();
					if (got.pairs !== want.pairs)
						report_mismatch("pairs_this_item", got.pairs, want.pairs);
					if (got.total !== want.total)
						report_mismatch("running_total", got.total, want.total);
					if (got.overflow !== want.overflow)
						report_mismatch("overflow", got.overflow, want.overflow);
				end
				n_results++;
			end
			if (idling && stall_left == 0 && $urandom_range(0, 7) == 0)
				stall_left = $urandom_range(1, 6);
			if (stall_left > 0) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin
		int   n_items;
		logic st;
		idling    = 1'b1;
		xor_lim   = '0;
		n_held    = 0;
		set_total = 0;
		new_clusters();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i]) begin
			if (DIRECTED[i].set_lim)
				write_limit(DIRECTED[i].lim);
			send_value(DIRECTED[i].value, DIRECTED[i].start, DIRECTED[i].typed, DIRECTED[i].want);
		end

		// Short sets under changing limits, one phase with no idling.
		for (int ph = 0; ph < 4; ph++) begin
			write_limit(pick_limit());
			idling  = (ph % 4 != 3);
			n_items = $urandom_range(8, 16);
			for (int i = 0; i < n_items; i++) begin
				st = (i == 0 && $urandom_range(0, 1) == 1) || $urandom_range(0, 24) == 0;
				if (st)
					new_clusters();
				send_value(near_value(), st, 1'b0, '0);
			end
		end

		// One long set: fill past item capacity and push the total into saturation.
		idling = 1'b1;
		new_clusters();
		write_limit(LIM_ALL);
		for (int i = 0; i < 600; i++)
			send_value(near_value(), i == 0, 1'b0, '0);
		idling = 1'b0;
		for (int i = 0; i < 430; i++)
			send_value(near_value(), 1'b0, 1'b0, '0);

		s_axis_tvalid <= 1'b0;
		while (awaited_tallies.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (n_errors == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule

>>> sim.f
+incdir+src
src/xpbl_pkg.sv
src/xpbl_ram.sv
src/xpbl_engine.sv
src/xpbl_out_reg.sv
src/xor_pair_below_limit_counter.sv
test/tb_top.sv
